@@ hdl/timed_task_table_scheduler_macros.svh @@
// Assertion macros for the scheduler RTL.
`ifndef TIMED_TASK_TABLE_SCHEDULER_MACROS_SVH
`define TIMED_TASK_TABLE_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TTS_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TTS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/tts_pkg.sv @@
// Types and constants of the timed task table scheduler.
`default_nettype none

package tts_pkg;

  localparam int TTS_SLOTS_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int ID_W          = 8;
  localparam int TIME_W        = 32;
  localparam int HELD_W        = 5;

  typedef enum logic [1:0] {
    ACT_SET      = 2'd0,
    ACT_DEL      = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_DISPATCH = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  // Operation broadcast to every cell.
  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_SET       = 3'd1,
    OP_DEL       = 3'd2,
    OP_TICK      = 3'd3,
    OP_FIRE_KEEP = 3'd4,
    OP_FIRE_DROP = 3'd5
  } cell_op_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
    logic              ready;
  } entry_t;

  typedef struct packed {
    cell_op_t          op;
    logic              found;
    logic              tok_load;
    logic              tok_adv;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
    entry_t            tail;
  } cell_bcast_t;

  typedef struct packed {
    logic   tok;
    logic   hit;
    logic   match;
    logic   tail;
    entry_t entry;
  } cell_view_t;

endpackage

`default_nettype wire

@@ hdl/tts_cell.sv @@
// One table slot: entry storage, tick/rearm arithmetic and the walk token.
`default_nettype none

module tts_cell import tts_pkg::*; #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [CW-1:0] count,
  input  wire logic          tok_prev,
  input  wire cell_bcast_t   bc,
  output cell_view_t         view
);

  logic [ID_W-1:0]   id_r;
  logic [TIME_W-1:0] delay_r;
  logic [TIME_W-1:0] period_r;
  logic              ready_r;
  logic              tok_r, tok_nxt;
  logic              valid, is_tail, match, is_append;

  assign valid     = CW'(IDX) < count;
  assign is_tail   = CW'(IDX + 1) == count;
  assign match     = valid && (id_r == bc.id);
  assign is_append = CW'(IDX) == count;

  always_comb begin
    tok_nxt = tok_r;
    if (bc.tok_load) begin
      tok_nxt = (IDX == 0);
    end else if (bc.tok_adv) begin
      tok_nxt = tok_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (bc.op)
      OP_SET: begin
        if (match || (!bc.found && is_append)) begin
          id_r     <= bc.id;
          delay_r  <= bc.delay;
          period_r <= bc.period;
          ready_r  <= 1'b0;
        end
      end
      OP_DEL: begin
        if (match && !is_tail) begin
          {id_r, delay_r, period_r, ready_r} <= bc.tail;
        end
      end
      OP_TICK: begin
        if (valid) begin
          if (delay_r == '0) begin
            ready_r <= 1'b1;
          end else begin
            delay_r <= delay_r - TIME_W'(1);
          end
        end
      end
      OP_FIRE_DROP: begin
        if (tok_r && !is_tail) begin
          {id_r, delay_r, period_r, ready_r} <= bc.tail;
        end
      end
      OP_FIRE_KEEP: begin
        if (tok_r) begin
          ready_r <= 1'b0;
          if (delay_r == '0) begin
            delay_r <= period_r - TIME_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign view.tok          = tok_r;
  assign view.hit          = tok_r && valid;
  assign view.match        = match;
  assign view.tail         = is_tail;
  assign view.entry.id     = id_r;
  assign view.entry.delay  = delay_r;
  assign view.entry.period = period_r;
  assign view.entry.ready  = ready_r;

endmodule

`default_nettype wire

@@ hdl/tts_fire_queue.sv @@
// Holds the ids fired by one dispatch walk until they are sent out.
`default_nettype none

module tts_fire_queue import tts_pkg::*; #(
  parameter int DEPTH = MAX_RESULTS
) (
  input  wire logic                     clk,
  input  wire logic                     push,
  input  wire logic [$clog2(DEPTH)-1:0] push_idx,
  input  wire logic [ID_W-1:0]          push_id,
  input  wire logic                     pop,
  output logic      [ID_W-1:0]          head
);

  logic [ID_W-1:0] q_r [DEPTH];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[push_idx] <= push_id;
    end else if (pop) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        q_r[k] <= q_r[k+1];
      end
    end
  end

  assign head = q_r[0];

endmodule

`default_nettype wire

@@ hdl/timed_task_table_scheduler.sv @@
// Top level of the timed task table scheduler: control, cell row and result port.
//
// A command is taken when start is high and busy is low. Set, delete and tick
// give a single result beat on the out_ ports in the next cycle, and a new
// command may be issued right away. Dispatch walks the row of slot cells with
// a token, one slot per cycle (when a one-shot task is removed, its replacement
// is examined next), until it passes the end of the table or 16 tasks have
// fired; it then sends one beat per fired task, one per cycle, or a single beat
// with out_fired low if none fired. Busy is low again when the last beat shows.
// Result beats are strobed by out_valid for one cycle and cannot be held off;
// out_tasks_held carries the entry count after the whole command.
`default_nettype none

module timed_task_table_scheduler import tts_pkg::*; #(
  parameter int TABLE_SLOTS = TTS_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_action,
  input  wire logic [ID_W-1:0]     in_task_id,
  input  wire logic [TIME_W-1:0]   in_start_delay,
  input  wire logic [TIME_W-1:0]   in_repeat_period,
  output logic                     out_valid,
  output logic [ID_W-1:0]          out_fired_task,
  output logic                     out_fired,
  output logic [1:0]               out_status,
  output logic [HELD_W-1:0]        out_tasks_held,
  output logic                     out_last
);

  `include "timed_task_table_scheduler_macros.svh"

  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int NW = $clog2(MAX_RESULTS + 1);
  localparam int QW = $clog2(MAX_RESULTS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [NW-1:0]     n_r, n_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_fired_task_r, out_fired_task_nxt;
  logic              out_fired_r, out_fired_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [HELD_W-1:0] out_tasks_held_r, out_tasks_held_nxt;
  logic              out_last_r, out_last_nxt;

  cell_bcast_t       bc;
  cell_view_t        views [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] tok_vec, hit_vec, match_vec;
  entry_t            sel_entry, tail_entry;
  logic              found, hit_any, accept;

  logic              q_push, q_pop;
  logic [ID_W-1:0]   q_head;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Cell row; the walk token moves from each cell to its right neighbor.
  for (genvar k = 0; k < TABLE_SLOTS; k++) begin : g_cell
    logic tok_prev;
    if (k == 0) begin : g_first
      assign tok_prev = 1'b0;
    end else begin : g_rest
      assign tok_prev = tok_vec[k-1];
    end

    tts_cell #(.CW(CW), .IDX(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .count    (count_r),
      .tok_prev (tok_prev),
      .bc       (bc),
      .view     (views[k])
    );

    assign tok_vec[k]   = views[k].tok;
    assign hit_vec[k]   = views[k].hit;
    assign match_vec[k] = views[k].match;
  end

  assign found   = |match_vec;
  assign hit_any = |hit_vec;

  // Token slot and tail slot are each at most one cell: plain OR select.
  always_comb begin
    sel_entry  = '0;
    tail_entry = '0;
    for (int k = 0; k < TABLE_SLOTS; k++) begin
      sel_entry  = sel_entry  | (views[k].hit  ? views[k].entry : '0);
      tail_entry = tail_entry | (views[k].tail ? views[k].entry : '0);
    end
  end

  always_comb begin
    state_nxt          = state_r;
    count_nxt          = count_r;
    n_nxt              = n_r;
    out_valid_nxt      = 1'b0;
    out_fired_task_nxt = '0;
    out_fired_nxt      = 1'b0;
    out_status_nxt     = STAT_DONE;
    out_tasks_held_nxt = HELD_W'(count_r);
    out_last_nxt       = 1'b1;
    q_push             = 1'b0;
    q_pop              = 1'b0;

    bc.op       = OP_NONE;
    bc.found    = found;
    bc.tok_load = 1'b0;
    bc.tok_adv  = 1'b0;
    bc.id       = in_task_id;
    bc.delay    = in_start_delay;
    bc.period   = in_repeat_period;
    bc.tail     = tail_entry;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (action_t'(in_action))
            ACT_SET: begin
              bc.op = OP_SET;
              if (!found) begin
                if (count_r == CW'(TABLE_SLOTS)) begin
                  out_status_nxt = STAT_FULL;
                end else begin
                  count_nxt = count_r + CW'(1);
                end
              end
              out_valid_nxt = 1'b1;
            end
            ACT_DEL: begin
              bc.op = OP_DEL;
              if (found) begin
                count_nxt = count_r - CW'(1);
              end else begin
                out_status_nxt = STAT_NOT_FOUND;
              end
              out_valid_nxt = 1'b1;
            end
            ACT_TICK: begin
              bc.op         = OP_TICK;
              out_valid_nxt = 1'b1;
            end
            default: begin
              bc.tok_load = 1'b1;
              n_nxt       = '0;
              state_nxt   = ST_WALK;
            end
          endcase
          out_tasks_held_nxt = HELD_W'(count_nxt);
        end
      end
      ST_WALK: begin
        if (!hit_any || n_r == NW'(MAX_RESULTS)) begin
          if (n_r == '0) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else if (sel_entry.ready) begin
          q_push = 1'b1;
          n_nxt  = n_r + NW'(1);
          if (sel_entry.period == '0) begin
            // moved-in tail entry is examined next, token stays
            bc.op     = OP_FIRE_DROP;
            count_nxt = count_r - CW'(1);
          end else begin
            bc.op      = OP_FIRE_KEEP;
            bc.tok_adv = 1'b1;
          end
        end else begin
          bc.tok_adv = 1'b1;
        end
      end
      ST_EMIT: begin
        q_pop              = 1'b1;
        n_nxt              = n_r - NW'(1);
        out_valid_nxt      = 1'b1;
        out_fired_task_nxt = q_head;
        out_fired_nxt      = 1'b1;
        out_last_nxt       = (n_r == NW'(1));
        if (n_r == NW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  tts_fire_queue #(.DEPTH(MAX_RESULTS)) u_queue (
    .clk      (clk),
    .push     (q_push),
    .push_idx (n_r[QW-1:0]),
    .push_id  (sel_entry.id),
    .pop      (q_pop),
    .head     (q_head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_fired_task_r <= out_fired_task_nxt;
    out_fired_r      <= out_fired_nxt;
    out_status_r     <= out_status_nxt;
    out_tasks_held_r <= out_tasks_held_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_fired_task = out_fired_task_r;
  assign out_fired      = out_fired_r;
  assign out_status     = out_status_r;
  assign out_tasks_held = out_tasks_held_r;
  assign out_last       = out_last_r;

  `TTS_ASSERT_NOW(a_count_range, 1'b1, count_r <= CW'(TABLE_SLOTS),
    "entry count above table size")
  `TTS_ASSERT_NOW(a_one_token, 1'b1, $onehot0(hit_vec),
    "walk token held by more than one live slot")
  `TTS_ASSERT_NOW(a_unfired_last, out_valid_r && !out_fired_r, out_last_r,
    "beat without a fired task must close its command")
  `TTS_ASSERT_NEXT(a_dispatch_busy, accept && (in_action == ACT_DISPATCH), busy,
    "dispatch did not start a walk")

endmodule

`default_nettype wire
